// ===== hdl/msp_pkg.sv =====
package msp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned IndexW = 6;

  localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DIRECTION = 2'd2;

  typedef struct packed {
    logic cap_size;
    logic cap_cmd;
    logic cap_data;
    logic burst_clr;
    logic rd_en;
    logic load_out;
  } msp_cmd_t;

  typedef struct packed {
    logic match_sync1;
    logic match_sync2;
    logic match_dir;
    logic size_ok;
    logic len_zero;
    logic fill_done;
    logic csum_ok;
    logic burst_last;
    logic out_free;
  } msp_sts_t;

endpackage

// ===== hdl/msp_frame_parser_top.sv =====
// Frame parser for a two-sync-byte serial command protocol.
// Input channel: one received byte per request on in_byte_i, taken at an edge
// where in_valid_i is high and in_stall_o is low. A frame is sync, sync,
// direction, size, command, payload and an XOR checksum over size, command
// and payload. Sync and direction values come from three registers written
// through cfg_we_i, cfg_index_i and cfg_data_i.
// After a matching checksum byte the payload is read back from the store,
// one byte per read. Each result with data comes from a store read followed
// by an output load, and the load waits while the output register still
// holds a stalled result. An empty payload skips the store read and gives
// a single result without data.
// in_stall_o is high while the burst is played out. The last result sits in
// the output register while parsing of the next frame goes on.
// When the receiver stalls, the output register holds its result and the
// burst waits. Rejected frames give no output. Reset returns the parser to
// hunting for the first sync byte, loads the default register values and
// empties the output register; the payload store needs no clearing.
module msp_frame_parser_top
  import msp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   in_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ByteW-1:0]   command_o,
  output logic               has_data_o,
  output logic [IndexW-1:0]  byte_index_o,
  output logic [ByteW-1:0]   data_byte_o,
  output logic               last_o
);

  msp_cmd_t cmd;
  msp_sts_t sts;

  msp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  msp_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_byte_i    (in_byte_i),
    .out_stall_i  (out_stall_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .command_o    (command_o),
    .has_data_o   (has_data_o),
    .byte_index_o (byte_index_o),
    .data_byte_o  (data_byte_o),
    .last_o       (last_o)
  );

endmodule

// ===== hdl/msp_ctrl.sv =====
module msp_ctrl
  import msp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  msp_sts_t sts_i,
  output msp_cmd_t cmd_o
);

  localparam logic [3:0] ST_SYNC1 = 4'd0;
  localparam logic [3:0] ST_SYNC2 = 4'd1;
  localparam logic [3:0] ST_DIR = 4'd2;
  localparam logic [3:0] ST_SIZE = 4'd3;
  localparam logic [3:0] ST_CMD = 4'd4;
  localparam logic [3:0] ST_DATA = 4'd5;
  localparam logic [3:0] ST_CHECK = 4'd6;
  localparam logic [3:0] ST_READ = 4'd7;
  localparam logic [3:0] ST_LOAD = 4'd8;

  logic [3:0] state_q, state_d;
  logic       bursting;
  logic       acc;

  assign bursting = (state_q == ST_READ) || (state_q == ST_LOAD);
  assign in_stall_o = bursting;
  assign acc = in_valid_i && !bursting;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      ST_SYNC1: begin
        if (acc) begin
          state_d = sts_i.match_sync1 ? ST_SYNC2 : ST_SYNC1;
        end
      end
      ST_SYNC2: begin
        if (acc) begin
          state_d = sts_i.match_sync2 ? ST_DIR : ST_SYNC1;
        end
      end
      ST_DIR: begin
        if (acc) begin
          state_d = sts_i.match_dir ? ST_SIZE : ST_SYNC1;
        end
      end
      ST_SIZE: begin
        if (acc) begin
          cmd_o.cap_size = sts_i.size_ok;
          state_d = sts_i.size_ok ? ST_CMD : ST_SYNC1;
        end
      end
      ST_CMD: begin
        if (acc) begin
          cmd_o.cap_cmd = 1'b1;
          state_d = sts_i.len_zero ? ST_CHECK : ST_DATA;
        end
      end
      ST_DATA: begin
        if (acc) begin
          cmd_o.cap_data = 1'b1;
          state_d = sts_i.fill_done ? ST_CHECK : ST_DATA;
        end
      end
      ST_CHECK: begin
        if (acc) begin
          cmd_o.burst_clr = sts_i.csum_ok;
          if (!sts_i.csum_ok) begin
            state_d = ST_SYNC1;
          end else begin
            state_d = sts_i.len_zero ? ST_LOAD : ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = sts_i.burst_last ? ST_SYNC1 : ST_READ;
        end
      end
      default: begin
        state_d = ST_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SYNC1;
    end else begin
      state_q <= state_d;
    end
  end

  a_read_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_LOAD))
    else $error("Payload read was not followed by an output load.");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("Output register loaded while a result was still waiting.");

endmodule

// ===== hdl/msp_dp.sv =====
module msp_dp
  import msp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  input  logic [ByteW-1:0]   in_byte_i,
  input  logic               out_stall_i,
  input  msp_cmd_t           cmd_i,
  output msp_sts_t           sts_o,
  output logic               out_valid_o,
  output logic [ByteW-1:0]   command_o,
  output logic               has_data_o,
  output logic [IndexW-1:0]  byte_index_o,
  output logic [ByteW-1:0]   data_byte_o,
  output logic               last_o
);

  localparam int unsigned FlW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [ByteW-1:0] sync_first_q, sync_second_q, direction_q;
  logic [FlW-1:0]   frame_length_q;
  logic [FlW-1:0]   fill_pos_q;
  logic [FlW-1:0]   burst_idx_q;
  logic [ByteW-1:0] frame_cmd_q;
  logic [ByteW-1:0] run_xor_q;
  logic [ByteW-1:0] rdata_q;
  logic [ByteW-1:0] mem_q [MAX_PAYLOAD];

  logic             out_valid_q;
  logic [ByteW-1:0] out_cmd_q;
  logic             out_has_q;
  logic [IndexW-1:0] out_idx_q;
  logic [ByteW-1:0] out_data_q;
  logic             out_last_q;

  logic [FlW:0]     fill_inc;
  logic [FlW:0]     burst_inc;

  assign fill_inc = {1'b0, fill_pos_q} + 1'b1;
  assign burst_inc = {1'b0, burst_idx_q} + 1'b1;

  assign sts_o.match_sync1 = (in_byte_i == sync_first_q);
  assign sts_o.match_sync2 = (in_byte_i == sync_second_q);
  assign sts_o.match_dir = (in_byte_i == direction_q);
  assign sts_o.size_ok = (in_byte_i <= ByteW'(MAX_PAYLOAD));
  assign sts_o.len_zero = (frame_length_q == '0);
  assign sts_o.fill_done = (fill_inc >= {1'b0, frame_length_q});
  assign sts_o.csum_ok = (run_xor_q == in_byte_i);
  assign sts_o.burst_last = (frame_length_q == '0) ||
                            (burst_inc == {1'b0, frame_length_q});
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q <= 8'd36;
      sync_second_q <= 8'd77;
      direction_q <= 8'd62;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SYNC_FIRST: sync_first_q <= cfg_data_i;
        CFG_SYNC_SECOND: sync_second_q <= cfg_data_i;
        CFG_DIRECTION: direction_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_length_q <= '0;
      fill_pos_q <= '0;
      frame_cmd_q <= '0;
      run_xor_q <= '0;
      burst_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cap_size) begin
        frame_length_q <= in_byte_i[FlW-1:0];
        fill_pos_q <= '0;
        run_xor_q <= in_byte_i;
      end
      if (cmd_i.cap_cmd) begin
        frame_cmd_q <= in_byte_i;
        run_xor_q <= run_xor_q ^ in_byte_i;
      end
      if (cmd_i.cap_data) begin
        fill_pos_q <= fill_inc[FlW-1:0];
        run_xor_q <= run_xor_q ^ in_byte_i;
      end
      if (cmd_i.burst_clr) begin
        burst_idx_q <= '0;
      end else if (cmd_i.load_out) begin
        burst_idx_q <= burst_inc[FlW-1:0];
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_data) begin
      mem_q[fill_pos_q[AddrW-1:0]] <= in_byte_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[burst_idx_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_cmd_q <= frame_cmd_q;
      out_has_q <= !sts_o.len_zero;
      out_idx_q <= IndexW'(burst_idx_q);
      out_data_q <= sts_o.len_zero ? '0 : rdata_q;
      out_last_q <= sts_o.burst_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign command_o = out_cmd_q;
  assign has_data_o = out_has_q;
  assign byte_index_o = out_idx_q;
  assign data_byte_o = out_data_q;
  assign last_o = out_last_q;

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_pos_q <= frame_length_q)
    else $error("Payload fill position ran past the frame length.");

  a_burst_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && !sts_o.len_zero) |-> (burst_idx_q < frame_length_q))
    else $error("Burst index ran past the frame length.");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_has_q) |-> (out_last_q && (out_data_q == '0)))
    else $error("Empty-payload result is not a single final result.");

endmodule
